// ===== rtl/core/kmad_pkg.sv =====
package kmad_pkg;

    localparam int ROW_COUNT = 7;
    localparam int COL_COUNT = 8;
    localparam int CODE_W    = 7;
    localparam int ROW_W     = 3;

    localparam logic [CODE_W-1:0] LOWER_A     = 7'h61;
    localparam logic [CODE_W-1:0] CASE_DELTA  = 7'h20;
    localparam logic [CODE_W-1:0] PUNCT_DELTA = 7'h10;

    // Key table, row-major; column 0 is bit 7 of the row byte.
    localparam logic [CODE_W-1:0] KEY_MAP [0:ROW_COUNT*COL_COUNT-1] = '{
        7'h79, 7'h7a, 7'h40, 7'h00, 7'h00, 7'h00, 7'h00, 7'h00,
        7'h71, 7'h72, 7'h73, 7'h74, 7'h75, 7'h76, 7'h77, 7'h78,
        7'h69, 7'h6a, 7'h6b, 7'h6c, 7'h6d, 7'h6e, 7'h6f, 7'h70,
        7'h61, 7'h62, 7'h63, 7'h64, 7'h65, 7'h66, 7'h67, 7'h68,
        7'h31, 7'h32, 7'h33, 7'h34, 7'h35, 7'h36, 7'h37, 7'h38,
        7'h2a, 7'h2b, 7'h2d, 7'h20, 7'h30, 7'h39, 7'h2c, 7'h2e,
        7'h00, 7'h00, 7'h6b, 7'h6a, 7'h6c, 7'h68, 7'h3f, 7'h2f
    };

    // Keys whose code shift alters, in row-byte bit layout.
    localparam logic [COL_COUNT-1:0] SHIFTABLE_KEYS [0:ROW_COUNT-1] = '{
        8'h00, 8'hd2, 8'h01, 8'h00, 8'h00, 8'h03, 8'h00
    };

    typedef struct packed {
        logic              hit;
        logic [CODE_W-1:0] code;
    } t_lane_res;

    typedef struct packed {
        logic [CODE_W-1:0] key_code;
        logic              key_valid;
        logic [ROW_W-1:0]  row_found;
    } t_key_res;

endpackage

// ===== rtl/core/kmad_if.sv =====
interface kmad_scan_if;
    logic       valid;
    logic       ready;
    logic [7:0] row1_bits;
    logic [7:0] row2_bits;
    logic [7:0] row3_bits;
    logic [7:0] row4_bits;
    logic [7:0] row5_bits;
    logic [7:0] row6_bits;
    logic [7:0] row7_bits;
    logic       shift_held;

    modport source (
        output valid, row1_bits, row2_bits, row3_bits, row4_bits,
               row5_bits, row6_bits, row7_bits, shift_held,
        input  ready
    );
    modport sink (
        input  valid, row1_bits, row2_bits, row3_bits, row4_bits,
               row5_bits, row6_bits, row7_bits, shift_held,
        output ready
    );
endinterface

interface kmad_key_if;
    logic       valid;
    logic       ready;
    logic [6:0] key_code;
    logic       key_valid;
    logic [2:0] row_found;

    modport source (
        output valid, key_code, key_valid, row_found,
        input  ready
    );
    modport sink (
        input  valid, key_code, key_valid, row_found,
        output ready
    );
endinterface

// ===== rtl/core/kmad_row_lane.sv =====
module kmad_row_lane #(
    parameter int ROW_IDX = 0
) (
    input  logic [kmad_pkg::COL_COUNT-1:0] i_bits,
    input  logic                           i_shift,
    output kmad_pkg::t_lane_res            o_res
);
    import kmad_pkg::*;

    localparam int COL_IDX_W = $clog2(COL_COUNT);

    logic [COL_IDX_W-1:0] top_bit;
    logic [COL_IDX_W-1:0] col;
    logic [CODE_W-1:0]    base_code;
    logic                 any_bit;
    logic                 shifted;

    // Highest set bit wins.
    always_comb begin
        top_bit = '0;
        for (int b = 0; b < COL_COUNT; b++) begin
            if (i_bits[b]) begin
                top_bit = COL_IDX_W'(b);
            end
        end
    end

    assign any_bit   = |i_bits;
    assign col       = COL_IDX_W'(COL_COUNT - 1) - top_bit;
    assign base_code = KEY_MAP[ROW_IDX*COL_COUNT + int'(col)];
    assign shifted   = i_shift && SHIFTABLE_KEYS[ROW_IDX][top_bit];

    always_comb begin
        o_res.hit  = any_bit && (base_code != '0);
        o_res.code = base_code;
        if (shifted) begin
            if (base_code >= LOWER_A) begin
                o_res.code = base_code - CASE_DELTA;
            end else begin
                o_res.code = base_code + PUNCT_DELTA;
            end
        end
    end

endmodule

// ===== rtl/core/kmad_merge.sv =====
module kmad_merge (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  kmad_pkg::t_lane_res i_lanes [kmad_pkg::ROW_COUNT],
    input  logic                i_valid,
    output logic                o_ready,
    output logic                o_valid,
    output kmad_pkg::t_key_res  o_res,
    input  logic                i_ready
);
    import kmad_pkg::*;

    t_key_res sel;
    t_key_res r_out, n_out;
    t_key_res r_skid, n_skid;
    logic     r_out_valid, n_out_valid;
    logic     r_skid_valid, n_skid_valid;
    logic     in_fire;

    // Lowest-numbered row with a hit wins.
    always_comb begin
        sel = '0;
        for (int r = ROW_COUNT - 1; r >= 0; r--) begin
            if (i_lanes[r].hit) begin
                sel.key_code  = i_lanes[r].code;
                sel.key_valid = 1'b1;
                sel.row_found = ROW_W'(r + 1);
            end
        end
    end

    assign o_ready = !r_skid_valid;
    assign in_fire = i_valid && o_ready;

    always_comb begin
        n_out        = r_out;
        n_out_valid  = r_out_valid;
        n_skid       = r_skid;
        n_skid_valid = r_skid_valid;
        if (!r_out_valid || i_ready) begin
            // output slot frees up: drain skid first, else take new transfer
            if (r_skid_valid) begin
                n_out        = r_skid;
                n_out_valid  = 1'b1;
                n_skid_valid = 1'b0;
            end else begin
                n_out       = sel;
                n_out_valid = in_fire;
            end
        end else if (in_fire) begin
            // output stalled: park the new result
            n_skid       = sel;
            n_skid_valid = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else begin
            r_out_valid  <= n_out_valid;
            r_skid_valid <= n_skid_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out  <= n_out;
        r_skid <= n_skid;
    end

    assign o_valid = r_out_valid;
    assign o_res   = r_out;

endmodule

// ===== rtl/core/key_matrix_to_ascii_decoder.sv =====
// Channel  | Dir | Payload
// ---------+-----+------------------------------------------------
// i_scan   | in  | row1_bits..row7_bits (8b each), shift_held (1b)
// o_key    | out | key_code (7b), key_valid (1b), row_found (3b)
//
// One scan per cycle while ready is high; each result enters the output
// register, or waits in the skid slot while the output stalls.
// Seven row lanes decode in parallel, a priority merge picks the first row.
// Output register plus a one-entry skid: input stays ready while a result
// waits, and drops ready only when both slots are full.
// Synchronous active-low reset empties both slots.
module key_matrix_to_ascii_decoder (
    input  logic        i_clk,
    input  logic        i_rst_n,
    kmad_scan_if.sink   i_scan,
    kmad_key_if.source  o_key
);
    import kmad_pkg::*;

    logic [COL_COUNT-1:0] row_bits [ROW_COUNT];
    t_lane_res            lanes    [ROW_COUNT];
    t_key_res             res;

    assign row_bits[0] = i_scan.row1_bits;
    assign row_bits[1] = i_scan.row2_bits;
    assign row_bits[2] = i_scan.row3_bits;
    assign row_bits[3] = i_scan.row4_bits;
    assign row_bits[4] = i_scan.row5_bits;
    assign row_bits[5] = i_scan.row6_bits;
    assign row_bits[6] = i_scan.row7_bits;

    for (genvar g = 0; g < ROW_COUNT; g++) begin : g_lane
        kmad_row_lane #(
            .ROW_IDX (g)
        ) u_lane (
            .i_bits  (row_bits[g]),
            .i_shift (i_scan.shift_held),
            .o_res   (lanes[g])
        );
    end

    kmad_merge u_merge (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_lanes (lanes),
        .i_valid (i_scan.valid),
        .o_ready (i_scan.ready),
        .o_valid (o_key.valid),
        .o_res   (res),
        .i_ready (o_key.ready)
    );

    assign o_key.key_code  = res.key_code;
    assign o_key.key_valid = res.key_valid;
    assign o_key.row_found = res.row_found;

endmodule

// ===== dv/tb.sv =====
`timescale 1ns / 100ps

module tb;

    import kmad_pkg::*;

    localparam int RAND_PER_PHASE = 280;
    localparam int MAX_REPORTS    = 10;

    // Own copy of the key layout, row-major, column 0 is bit 7 of the row byte.
    localparam logic [7:0] KEY_CHARS [56] = '{
        "y", "z", "@", 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
        "q", "r", "s", "t",   "u",   "v",   "w",   "x",
        "i", "j", "k", "l",   "m",   "n",   "o",   "p",
        "a", "b", "c", "d",   "e",   "f",   "g",   "h",
        "1", "2", "3", "4",   "5",   "6",   "7",   "8",
        "*", "+", "-", " ",   "0",   "9",   ",",   ".",
        8'h00, 8'h00, "k", "j", "l", "h",   "?",   "/"
    };
    localparam logic [7:0] SHIFTABLE [1:7] = '{8'h00, 8'hd2, 8'h01, 8'h00, 8'h00, 8'h03, 8'h00};
    localparam logic [7:0] UPPER_OFFSET = "a" - "A";
    localparam logic [7:0] PUNCT_OFFSET = "<" - ",";

    typedef struct packed {
        logic [1:7][7:0] rows;
        logic            shift;
    } t_scan;

    // typed = 1: the expected key is given in the row, else the predictor decides.
    typedef struct packed {
        logic [1:7][7:0] rows;
        logic            shift;
        logic            typed;
        logic [6:0]      code;
        logic            hit;
        logic [2:0]      row;
    } t_scan_case;

    localparam int NUM_CASES = 24;
    localparam t_scan_case SCAN_CASES [NUM_CASES] = '{
        '{56'h00_00_00_00_00_00_00, 1'b0, 1'b1, 7'h00, 1'b0, 3'd0},
        '{56'hff_ff_ff_ff_ff_ff_ff, 1'b0, 1'b1, 7'h79, 1'b1, 3'd1},
        '{56'hff_ff_ff_ff_ff_ff_ff, 1'b1, 1'b1, 7'h79, 1'b1, 3'd1},
        '{56'h1f_00_00_00_00_00_00, 1'b1, 1'b1, 7'h00, 1'b0, 3'd0},
        '{56'h00_00_00_00_00_00_c0, 1'b0, 1'b1, 7'h00, 1'b0, 3'd0},
        '{56'h00_00_00_00_00_00_ff, 1'b1, 1'b1, 7'h00, 1'b0, 3'd0},
        '{56'h01_80_00_00_00_00_00, 1'b1, 1'b0, 7'h00, 1'b0, 3'd0},
        '{56'h00_80_00_00_00_00_00, 1'b0, 1'b0, 7'h00, 1'b0, 3'd0},
        '{56'h00_40_00_00_00_00_00, 1'b1, 1'b0, 7'h00, 1'b0, 3'd0},
        '{56'h00_01_00_00_00_00_00, 1'b1, 1'b0, 7'h00, 1'b0, 3'd0},
        '{56'h00_10_00_00_00_00_00, 1'b1, 1'b0, 7'h00, 1'b0, 3'd0},
        '{56'h00_02_00_00_00_00_00, 1'b1, 1'b0, 7'h00, 1'b0, 3'd0},
        '{56'h00_00_01_00_00_00_00, 1'b1, 1'b0, 7'h00, 1'b0, 3'd0},
        '{56'h00_00_02_00_00_00_00, 1'b1, 1'b0, 7'h00, 1'b0, 3'd0},
        '{56'h00_00_00_00_00_02_00, 1'b1, 1'b0, 7'h00, 1'b0, 3'd0},
        '{56'h00_00_00_00_00_01_00, 1'b1, 1'b0, 7'h00, 1'b0, 3'd0},
        '{56'h00_00_00_00_00_01_00, 1'b0, 1'b0, 7'h00, 1'b0, 3'd0},
        '{56'h00_00_00_00_00_00_01, 1'b1, 1'b0, 7'h00, 1'b0, 3'd0},
        '{56'h00_00_00_00_00_00_3f, 1'b0, 1'b0, 7'h00, 1'b0, 3'd0},
        '{56'h00_00_00_80_ff_00_00, 1'b1, 1'b0, 7'h00, 1'b0, 3'd0},
        '{56'h00_00_00_00_01_ff_00, 1'b0, 1'b0, 7'h00, 1'b0, 3'd0},
        '{56'h00_00_00_00_00_80_00, 1'b1, 1'b0, 7'h00, 1'b0, 3'd0},
        '{56'h20_00_80_00_00_00_00, 1'b1, 1'b0, 7'h00, 1'b0, 3'd0},
        '{56'h40_00_00_00_00_00_00, 1'b1, 1'b0, 7'h00, 1'b0, 3'd0}
    };

    logic i_clk;
    logic i_rst_n;

    kmad_scan_if scan_if ();
    kmad_key_if  key_if ();

    key_matrix_to_ascii_decoder u_top (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_scan  (scan_if),
        .o_key   (key_if)
    );

    t_key_res expected_keys [$];
    int       send_idle_pct;
    int       recv_idle_pct;
    int       mismatches;
    int       scans_sent;
    int       keys_checked;
    int       keys_blank;

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    initial begin
        #5ms;
        $display("simulation failed");
        $finish;
    end

    // Priority decode: first row whose top pressed key maps to a real code wins.
    function automatic t_key_res decode_scan(t_scan s);
        t_key_res   res;
        logic [7:0] code;
        int         col;
        bit         done;
        res  = '0;
        done = 1'b0;
        for (int r = 1; r <= 7; r++) begin
            if (!done && s.rows[r] != 8'h00) begin
                col = 0;
                while (!s.rows[r][7 - col]) col++;
                code = KEY_CHARS[(r - 1) * 8 + col];
                if (code != 8'h00) begin
                    if (s.shift && SHIFTABLE[r][7 - col]) begin
                        code = (code >= "a") ? code - UPPER_OFFSET : code + PUNCT_OFFSET;
                    end
                    res.key_code  = code[6:0];
                    res.key_valid = 1'b1;
                    res.row_found = 3'(r);
                    done          = 1'b1;
                end
            end
        end
        return res;
    endfunction

    function automatic t_scan rand_scan();
        t_scan s;
        int    kind;
        s       = '0;
        kind    = $urandom_range(99);
        s.shift = 1'($urandom_range(1));
        for (int r = 1; r <= 7; r++) begin
            if (kind < 25) begin
                s.rows[r] = 8'($urandom);
            end else if (kind < 85) begin
                // mostly idle rows with a key or two pressed here and there
                case ($urandom_range(9))
                    0, 1:    s.rows[r] = 8'h01 << $urandom_range(7);
                    2:       s.rows[r] = 8'($urandom & $urandom);
                    default: s.rows[r] = 8'h00;
                endcase
            end
        end
        if (kind >= 85) begin
            // top key on an empty slot, maybe a real key further down
            s.rows[1] = 8'($urandom_range(31));
            s.rows[7] = 8'($urandom);
            if (s.rows[7][7:6] == 2'b00) s.rows[7][7] = 1'b1;
            if ($urandom_range(1)) s.rows[$urandom_range(2, 6)] = 8'($urandom);
        end
        return s;
    endfunction

    task automatic note_mismatch(string what, int exp_v, int act_v);
        mismatches++;
        if (mismatches <= MAX_REPORTS) begin
            $display("%0t: mismatch on %s: expected 0x%0h, got 0x%0h", $realtime, what, exp_v,
                     act_v);
        end
    endtask

    // Call at a falling edge; returns at the falling edge after the transfer.
    task automatic send_scan(t_scan s, t_key_res exp_key);
        while ($urandom_range(99) < send_idle_pct) begin
            scan_if.valid <= 1'b0;
            @(negedge i_clk);
        end
        scan_if.valid      <= 1'b1;
        scan_if.row1_bits  <= s.rows[1];
        scan_if.row2_bits  <= s.rows[2];
        scan_if.row3_bits  <= s.rows[3];
        scan_if.row4_bits  <= s.rows[4];
        scan_if.row5_bits  <= s.rows[5];
        scan_if.row6_bits  <= s.rows[6];
        scan_if.row7_bits  <= s.rows[7];
        scan_if.shift_held <= s.shift;
        do @(posedge i_clk); while (!scan_if.ready);
        expected_keys.push_back(exp_key);
        scans_sent++;
        @(negedge i_clk);
    endtask

    initial begin
        key_if.ready = 1'b0;
        forever begin
            @(negedge i_clk);
            key_if.ready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    always @(posedge i_clk) begin
        t_key_res exp_key;
        if (i_rst_n && key_if.valid && key_if.ready) begin
            if (expected_keys.size() == 0) begin
                note_mismatch("unexpected key transfer", 0, key_if.key_code);
            end else begin
                exp_key = expected_keys.pop_front();
                keys_checked++;
                if (!exp_key.key_valid) keys_blank++;
                if (key_if.key_code !== exp_key.key_code)
                    note_mismatch("key_code", exp_key.key_code, key_if.key_code);
                if (key_if.key_valid !== exp_key.key_valid)
                    note_mismatch("key_valid", exp_key.key_valid, key_if.key_valid);
                if (key_if.row_found !== exp_key.row_found)
                    note_mismatch("row_found", exp_key.row_found, key_if.row_found);
            end
        end
    end

    initial begin
        t_scan    s;
        t_key_res exp_key;
        scan_if.valid      = 1'b0;
        scan_if.row1_bits  = '0;
        scan_if.row2_bits  = '0;
        scan_if.row3_bits  = '0;
        scan_if.row4_bits  = '0;
        scan_if.row5_bits  = '0;
        scan_if.row6_bits  = '0;
        scan_if.row7_bits  = '0;
        scan_if.shift_held = 1'b0;
        send_idle_pct      = 30;
        recv_idle_pct      = 63;
        mismatches         = 0;
        scans_sent         = 0;
        keys_checked       = 0;
        keys_blank         = 0;
        i_rst_n            = 1'b0;
        repeat (10) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        for (int i = 0; i < NUM_CASES; i++) begin
            s.rows  = SCAN_CASES[i].rows;
            s.shift = SCAN_CASES[i].shift;
            if (SCAN_CASES[i].typed) begin
                exp_key.key_code  = SCAN_CASES[i].code;
                exp_key.key_valid = SCAN_CASES[i].hit;
                exp_key.row_found = SCAN_CASES[i].row;
            end else begin
                exp_key = decode_scan(s);
            end
            send_scan(s, exp_key);
        end

        for (int phase = 0; phase < 3; phase++) begin
            case (phase)
                0: begin send_idle_pct = 30; recv_idle_pct = 63; end
                1: begin send_idle_pct = 63; recv_idle_pct = 30; end
                default: begin send_idle_pct = 0; recv_idle_pct = 0; end
            endcase
            for (int n = 0; n < RAND_PER_PHASE; n++) begin
                s = rand_scan();
                send_scan(s, decode_scan(s));
            end
        end
        scan_if.valid <= 1'b0;

        // drain, then keep watching the output stage for a stray transfer
        while (expected_keys.size() != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);

        $display("Sent %0d scans (%0d directed), checked %0d keys, %0d of them blank.",
                 scans_sent, NUM_CASES, keys_checked, keys_blank);
        $display("Field mismatches: %0d.", mismatches);
        if (mismatches == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule

// ===== files.f =====
rtl/core/kmad_pkg.sv
rtl/core/kmad_if.sv
rtl/core/kmad_row_lane.sv
rtl/core/kmad_merge.sv
rtl/core/key_matrix_to_ascii_decoder.sv
dv/tb.sv
